@@ rtl/itoa_pkg.sv @@
package itoa_pkg;

  // one ASCII character
  typedef logic [7:0] char_t;

  localparam char_t MINUS_CODE = 8'd45;
  localparam char_t ZERO_CODE  = 8'd48;
  localparam char_t NINE_CODE  = 8'd57;

  // magnitude bits folded into the decimal register per conversion cycle
  localparam int STEP_BITS = 4;

endpackage

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// Signed integer to decimal ASCII text.
// Input channel: drive value and raise push; the word is taken at a rising
// edge where push is high and full is low. Each value yields its decimal
// text, one character per output word: '-' for a negative value, then the
// digits most significant first, no leading zeros; zero gives "0".
// last_char marks the final character of each value's text.
// Output channel: while empty is low, char_code/last_char hold the oldest
// character; it is taken at a rising edge where pop is high.
// Flow: a taken value passes the front register and the two-word queue,
// then the converter folds four magnitude bits per cycle into a BCD register,
// finds the leading digit, then issues one character per cycle while the
// receiver keeps popping. The back end takes the next value as it issues
// the final character of the previous one.
// The front and queue keep taking values while the back end converts.
// A stalled receiver holds the output word and backs the block up into
// full. Reset (rst, synchronous) empties the queue and drops any partial text.
module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  full,
  output itoa_pkg::char_t       char_code,
  output logic                  last_char,
  output logic                  empty,
  input  logic                  pop
);
  import itoa_pkg::*;

  logic                f_valid;
  logic [VALUE_BITS:0] f_data;
  logic                f_ready;
  logic                q_valid;
  logic [VALUE_BITS:0] q_data;
  logic                q_ready;

  itoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .value     (value),
    .full      (full),
    .out_valid (f_valid),
    .out_data  (f_data),
    .out_ready (f_ready)
  );

  itoa_fifo #(.W(VALUE_BITS + 1)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_data  (f_data),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop_ready  (q_ready)
  );

  itoa_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_data   (q_data),
    .in_ready  (q_ready),
    .char_code (char_code),
    .last_char (last_char),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

@@ rtl/itoa_front.sv @@
module itoa_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  full,
  output logic                  out_valid,
  output logic [VALUE_BITS:0]   out_data,
  input  logic                  out_ready
);
  import itoa_pkg::*;

  logic                  hold_valid;
  logic                  negative;
  logic [VALUE_BITS-1:0] magnitude;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] raw_mag;

  // split sign and magnitude; the most negative value negates to itself,
  // which read unsigned is the exact magnitude
  assign raw     = value;
  assign raw_mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  assign full      = hold_valid && !out_ready;
  assign out_valid = hold_valid;
  assign out_data  = {negative, magnitude};

  // hold the classified word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!hold_valid || out_ready) begin
      hold_valid <= push;
    end
    if (push && !full) begin
      negative  <= raw[VALUE_BITS-1];
      magnitude <= raw_mag;
    end
  end

endmodule

@@ rtl/itoa_fifo.sv @@
module itoa_fifo #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  input  logic         pop_ready
);
  import itoa_pkg::*;

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue fill level out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill level");

endmodule

@@ rtl/itoa_back.sv @@
module itoa_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [VALUE_BITS:0]   in_data,
  output logic                  in_ready,
  output itoa_pkg::char_t       char_code,
  output logic                  last_char,
  output logic                  empty,
  input  logic                  pop
);
  import itoa_pkg::*;

  localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W = STEPS * STEP_BITS;
  localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int IW    = $clog2(NDIG);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_LEAD, S_EMIT} state_t;

  state_t                     state;
  logic [PAD_W-1:0]           shreg;
  logic [NDIG-1:0][3:0]       bcd;
  logic [NDIG-1:0][3:0]       dab;
  logic [NDIG*4:0]            flat;
  logic [CW-1:0]              cnt;
  logic [IW-1:0]              idx;
  logic [IW-1:0]              lead;
  logic                       pend_sign;
  logic                       out_valid;
  logic                       slot_free;
  logic                       final_char;
  logic                       take;

  assign slot_free  = !out_valid || pop;
  assign final_char = (state == S_EMIT) && slot_free && !pend_sign && (idx == '0);
  assign take       = in_valid && ((state == S_IDLE) || final_char);
  assign in_ready   = take;
  assign empty      = !out_valid;

  // four double-dabble steps: adjust each digit, then shift in one bit
  always_comb begin
    dab  = bcd;
    flat = '0;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (dab[d] >= 4'd5) dab[d] = dab[d] + 4'd3;
      end
      flat = {dab, shreg[PAD_W-1-s]};
      dab  = flat[NDIG*4-1:0];
    end
  end

  // locate the most significant nonzero digit
  always_comb begin
    lead = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i] != 4'd0) lead = IW'(i);
    end
  end

  // sequence conversion and character output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend_sign <= 1'b0;
    end else begin
      // drop the taken word unless the emit stage replaces it
      if (pop && out_valid && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) state <= S_CONV;
        end
        S_CONV: begin
          if (cnt == '0) begin
            state <= S_LEAD;
          end
        end
        S_LEAD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (pend_sign) begin
              pend_sign <= 1'b0;
            end else if (idx == '0) begin
              state <= take ? S_CONV : S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (take) pend_sign <= in_data[VALUE_BITS];
    end

    // datapath registers
    if (take) begin
      shreg <= PAD_W'(in_data[VALUE_BITS-1:0]);
      bcd   <= '0;
      cnt   <= CW'(STEPS - 1);
    end else if (state == S_CONV) begin
      bcd   <= dab;
      shreg <= {shreg[PAD_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
      cnt   <= cnt - 1'b1;
    end
    if (state == S_LEAD) begin
      idx <= lead;
    end else if (state == S_EMIT && slot_free && !pend_sign && idx != '0) begin
      idx <= idx - 1'b1;
    end
    if (state == S_EMIT && slot_free) begin
      if (pend_sign) begin
        char_code <= MINUS_CODE;
        last_char <= 1'b0;
      end else begin
        char_code <= ZERO_CODE + {4'b0, bcd[idx]};
        last_char <= (idx == '0);
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (32'(idx) < NDIG))
    else $error("digit index beyond digit count");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == MINUS_CODE) |-> !last_char)
    else $error("sign character marked as last");

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == MINUS_CODE ||
                   (char_code >= ZERO_CODE && char_code <= NINE_CODE)))
    else $error("character outside sign and digit codes");

  a_held_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(char_code) && $stable(last_char)))
    else $error("waiting character changed before it was taken");

endmodule
